@@ hw/rtl/charger_and_sleep_supervisor_assert.svh @@
// Assertion macros for the charger and sleep supervisor
`ifndef CHARGER_AND_SLEEP_SUPERVISOR_ASSERT_SVH
`define CHARGER_AND_SLEEP_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, held off during reset
`define CHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("supervisor assertion failed");

// Next-cycle implication, held off during reset
`define CHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("supervisor assertion failed");

`endif

@@ hw/rtl/chs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

    // Default width of the tick counters
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_LOW_POWER_TICKS = 4'd0;
    localparam t_cfg_idx CFG_LOCK_TICKS      = 4'd1;
    localparam t_cfg_idx CFG_SLEEP_TICKS     = 4'd2;
    localparam t_cfg_idx CFG_IDLE_OFF_TICKS  = 4'd3;

    localparam t_cfg_data LOW_POWER_TICKS_RST = 16'd400;
    localparam t_cfg_data LOCK_TICKS_RST      = 16'd200;
    localparam t_cfg_data SLEEP_TICKS_RST     = 16'd400;
    localparam t_cfg_data IDLE_OFF_TICKS_RST  = 16'd1000;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_write;

    // Debounce constants
    localparam logic [2:0] PRESENCE_MAX = 3'd6;
    localparam logic [4:0] FULL_MAX     = 5'd20;
    localparam logic [4:0] FULL_STEP    = 5'd5;
    localparam logic [4:0] FULL_RESET   = 5'd10;
    localparam int         LP_DRAIN     = 12;

    // Battery levels
    localparam logic signed [3:0] LEVEL_CRITICAL = -4'sd1;
    localparam logic signed [3:0] LEVEL_EMPTY    = 4'sd0;
    localparam logic signed [3:0] LEVEL_LOW      = 4'sd1;
    localparam logic signed [3:0] LEVEL_CAP      = 4'sd4;

    // Power modes
    typedef logic [3:0] t_mode;
    localparam t_mode MODE_OFF_FULL          = 4'd0;
    localparam t_mode MODE_OFF_CHARGING      = 4'd1;
    localparam t_mode MODE_OFF_NO_CHARGE     = 4'd2;
    localparam t_mode MODE_OFF_NO_CHARGE_FUL = 4'd3;
    localparam t_mode MODE_ON_NO_CHARGE      = 4'd4;
    localparam t_mode MODE_ON_CHARGING       = 4'd7;

    typedef struct packed {
        logic              vin_present;
        logic              charge_pin;
        logic              key_level;
        logic signed [3:0] battery_level;
        t_mode             power_mode;
        logic              switch_off;
    } t_in_item;

    typedef struct packed {
        logic              charger_connected;
        logic              battery_full;
        logic signed [3:0] display_level;
        logic              low_power_locked;
        logic              charge_stable;
        logic              sleep_entry;
        logic              power_off_request;
        logic              display_stop;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/chs_intf.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface chs_in_if;
    logic              valid;
    logic              ready;
    chs_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result item channel
interface chs_out_if;
    logic             valid;
    logic             ready;
    chs_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel
interface chs_cfg_if;
    logic                valid;
    logic                ready;
    chs_pkg::t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/charger_and_sleep_supervisor.sv @@
// An item passes from the input register through the combinational update into the result
// register, where the result is held until it is taken.
// Throughput: one item per cycle through the combinational update between the input and
// result registers; input stalls once a result waits and the input register is full.
// Reset (i_rst_n low, synchronous): counters and config go to their reset values,
// both pipeline registers are emptied; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "charger_and_sleep_supervisor_assert.svh"

module charger_and_sleep_supervisor #(
    parameter int COUNT_WIDTH = chs_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    chs_cfg_if.sink    i_cfg,
    chs_in_if.sink     i_in,
    chs_out_if.source  o_out
);

    localparam int CMP_W = (COUNT_WIDTH > chs_pkg::CFG_DATA_W) ? COUNT_WIDTH
                                                                 : chs_pkg::CFG_DATA_W;

    // Configuration registers
    chs_pkg::t_cfg_data r_low_power_ticks, r_lock_ticks, r_sleep_ticks, r_idle_off_ticks;

    // Pipeline registers
    logic              r_in_valid;
    chs_pkg::t_in_item r_in_data;
    logic              r_out_valid;
    chs_pkg::t_result  r_out_data;

    // Supervisor state
    logic [2:0]             r_pres_cnt, n_pres_cnt;
    logic [4:0]             r_full_cnt, n_full_cnt;
    logic                   r_conn, n_conn;
    logic                   r_full_flag, n_full_flag;
    logic [COUNT_WIDTH-1:0] r_lp_cnt, n_lp_cnt;
    logic                   r_lock, n_lock;
    logic [COUNT_WIDTH-1:0] r_sleep_cnt, n_sleep_cnt;
    logic [COUNT_WIDTH-1:0] r_idle_cnt, n_idle_cnt;

    chs_pkg::t_result  n_result;
    logic              fire;
    logic              key_pressed;
    logic signed [3:0] bat;
    logic [CMP_W-1:0]  sleep_preset;

    assign fire         = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready   = !r_in_valid || fire;
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out_data;
    assign key_pressed  = !r_in_data.key_level;
    assign bat          = r_in_data.battery_level;
    assign sleep_preset = CMP_W'(r_sleep_ticks) - CMP_W'(1);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_power_ticks <= chs_pkg::LOW_POWER_TICKS_RST;
            r_lock_ticks      <= chs_pkg::LOCK_TICKS_RST;
            r_sleep_ticks     <= chs_pkg::SLEEP_TICKS_RST;
            r_idle_off_ticks  <= chs_pkg::IDLE_OFF_TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                chs_pkg::CFG_LOW_POWER_TICKS: r_low_power_ticks <= i_cfg.data.value;
                chs_pkg::CFG_LOCK_TICKS:      r_lock_ticks      <= i_cfg.data.value;
                chs_pkg::CFG_SLEEP_TICKS:     r_sleep_ticks     <= i_cfg.data.value;
                chs_pkg::CFG_IDLE_OFF_TICKS:  r_idle_off_ticks  <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // Compute next state and result for the registered item
    always_comb begin
        n_pres_cnt  = r_pres_cnt;
        n_full_cnt  = r_full_cnt;
        n_conn      = r_conn;
        n_full_flag = r_full_flag;
        n_lp_cnt    = r_lp_cnt;
        n_lock      = r_lock;
        n_sleep_cnt = r_sleep_cnt;
        n_idle_cnt  = r_idle_cnt;
        n_result    = '0;

        // Debounce charger presence
        if (r_in_data.vin_present) begin
            if (r_pres_cnt < chs_pkg::PRESENCE_MAX) n_pres_cnt = r_pres_cnt + 3'd1;
            else n_conn = 1'b1;
        end else if (r_in_data.switch_off) begin
            n_full_cnt = chs_pkg::FULL_RESET;
            n_pres_cnt = 3'd0;
            n_conn     = 1'b0;
        end else begin
            n_full_cnt = chs_pkg::FULL_RESET;
            if (r_pres_cnt != 3'd0) n_pres_cnt = r_pres_cnt - 3'd1;
            else n_conn = 1'b0;
        end

        // Debounce charge-full
        if (r_in_data.charge_pin) begin
            if (n_full_cnt != 5'd0) n_full_cnt = n_full_cnt - 5'd1;
            else n_full_flag = 1'b0;
        end else begin
            if (n_full_cnt < chs_pkg::FULL_MAX) n_full_cnt = n_full_cnt + chs_pkg::FULL_STEP;
            else n_full_flag = 1'b1;
        end

        // Track low power and pick the displayed level
        if (n_conn) begin
            if (n_full_flag) begin
                if (r_lp_cnt > COUNT_WIDTH'(chs_pkg::LP_DRAIN)) begin
                    n_lp_cnt = r_lp_cnt - COUNT_WIDTH'(chs_pkg::LP_DRAIN);
                end else begin
                    n_lp_cnt = '0;
                    n_lock   = 1'b0;
                end
                n_result.display_level = chs_pkg::LEVEL_CAP;
            end else begin
                if (r_lp_cnt != '0) begin
                    n_lp_cnt = r_lp_cnt - COUNT_WIDTH'(1);
                    if (bat > chs_pkg::LEVEL_LOW) n_lock = 1'b0;
                end
                n_result.display_level = (bat > chs_pkg::LEVEL_CAP) ? chs_pkg::LEVEL_CAP : bat;
            end
        end else if (bat == chs_pkg::LEVEL_EMPTY || r_lock) begin
            n_result.display_level = chs_pkg::LEVEL_EMPTY;
            if (CMP_W'(r_lp_cnt) < CMP_W'(r_lock_ticks)) n_lp_cnt = r_lp_cnt + COUNT_WIDTH'(1);
            else n_lock = 1'b1;
        end else if (bat == chs_pkg::LEVEL_CRITICAL) begin
            n_result.display_level = chs_pkg::LEVEL_EMPTY;
            if (CMP_W'(r_lp_cnt) < CMP_W'(r_low_power_ticks)) begin
                n_lp_cnt = r_lp_cnt + COUNT_WIDTH'(1);
                // Preset the sleep counter once the critical period elapses
                if (CMP_W'(n_lp_cnt) >= CMP_W'(r_low_power_ticks)) begin
                    n_sleep_cnt = sleep_preset[COUNT_WIDTH-1:0];
                end
            end
        end else begin
            n_result.display_level = bat;
            if (bat > chs_pkg::LEVEL_LOW && r_lp_cnt != '0) begin
                n_lp_cnt = r_lp_cnt - COUNT_WIDTH'(1);
                n_lock   = 1'b0;
            end
        end

        // Run sleep and idle-off timers
        case (r_in_data.power_mode) inside
            chs_pkg::MODE_OFF_FULL, chs_pkg::MODE_OFF_CHARGING: begin
                n_sleep_cnt = '0;
            end
            chs_pkg::MODE_OFF_NO_CHARGE, chs_pkg::MODE_OFF_NO_CHARGE_FUL: begin
                if (CMP_W'(n_sleep_cnt) < CMP_W'(r_sleep_ticks)) begin
                    n_sleep_cnt = n_sleep_cnt + COUNT_WIDTH'(1);
                end else if (key_pressed) begin
                    n_sleep_cnt = '0;
                    n_lp_cnt    = '0;
                    if (!n_conn) begin
                        n_result.sleep_entry  = 1'b1;
                        n_result.display_stop = 1'b1;
                        n_idle_cnt            = '0;
                    end
                end
            end
            [chs_pkg::MODE_ON_NO_CHARGE:chs_pkg::MODE_ON_CHARGING]: begin
                n_sleep_cnt = '0;
                if (CMP_W'(n_lp_cnt) < CMP_W'(r_low_power_ticks)) begin
                    if (n_conn) begin
                        n_idle_cnt = '0;
                    end else if (CMP_W'(r_idle_off_ticks) > CMP_W'(r_idle_cnt)) begin
                        n_idle_cnt = r_idle_cnt + COUNT_WIDTH'(1);
                    end else begin
                        n_result.power_off_request = 1'b1;
                        n_result.display_stop      = 1'b1;
                    end
                end
            end
            default: begin
                n_lp_cnt    = '0;
                n_sleep_cnt = '0;
            end
        endcase

        n_result.charger_connected = n_conn;
        n_result.battery_full      = n_full_flag;
        n_result.low_power_locked  = n_lock;
        n_result.charge_stable     = (n_full_cnt >= chs_pkg::FULL_MAX || n_full_cnt == 5'd0)
                                  && (n_pres_cnt >= chs_pkg::PRESENCE_MAX || n_pres_cnt == 3'd0);
    end

    // Hold the input register until its item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_data <= i_in.data;
        end
    end

    // Advance state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pres_cnt  <= 3'd0;
            r_full_cnt  <= chs_pkg::FULL_RESET;
            r_conn      <= 1'b0;
            r_full_flag <= 1'b0;
            r_lp_cnt    <= '0;
            r_lock      <= 1'b0;
            r_sleep_cnt <= '0;
            r_idle_cnt  <= '0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_pres_cnt  <= n_pres_cnt;
                r_full_cnt  <= n_full_cnt;
                r_conn      <= n_conn;
                r_full_flag <= n_full_flag;
                r_lp_cnt    <= n_lp_cnt;
                r_lock      <= n_lock;
                r_sleep_cnt <= n_sleep_cnt;
                r_idle_cnt  <= n_idle_cnt;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= n_result;
        end
    end

    // Checks on the update logic
    `CHS_ASSERT_NEXT(a_fire_loads_result, i_clk, i_rst_n, fire, r_out_valid)
    `CHS_ASSERT_NEXT(a_pending_item_kept, i_clk, i_rst_n, r_in_valid && !fire, r_in_valid)
    `CHS_ASSERT_NOW(a_counts_in_range, i_clk, i_rst_n, 1'b1,
        r_pres_cnt <= chs_pkg::PRESENCE_MAX && r_full_cnt <= (chs_pkg::FULL_MAX + 5'd4))
    `CHS_ASSERT_NOW(a_sleep_stops_display, i_clk, i_rst_n, r_out_valid && r_out_data.sleep_entry,
        r_out_data.display_stop && !r_out_data.power_off_request && !r_out_data.charger_connected)

endmodule

`default_nettype wire

@@ tb/tb_charger_and_sleep_supervisor.sv @@
`timescale 1ns / 1ps

module tb_charger_and_sleep_supervisor;
    import chs_pkg::*;

    localparam int          IDLE_PCT     = 19;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          STUCK_LIMIT  = 2000;
    localparam int          MAX_REPORTS  = 10;
    localparam int          PHASE_ITEMS  = 92;
    localparam int unsigned CNT_MASK     = (1 << COUNT_WIDTH_DEF) - 1;

    // Power modes, a level and a config index the package leaves unnamed
    localparam t_mode            MODE_ON_NO_CHARGE_FULL = 4'd5;
    localparam t_mode            MODE_ON_FULL           = 4'd6;
    localparam t_mode            MODE_OTHER             = 4'd8;
    localparam t_mode            MODE_TOP               = 4'd15;
    localparam logic signed [3:0] LEVEL_UNMEASURED      = -4'sd2;
    localparam t_cfg_idx          CFG_IDX_SPARE         = 4'd9;

    // Supervisor state tracker and status checker
    class supervisor_scoreboard;
        int unsigned lp_ticks, lock_ticks, sleep_ticks, idle_ticks;
        int unsigned presence_cnt, full_cnt, lp_cnt, sleep_cnt, idle_cnt;
        bit          connected, full, locked;
        t_result     status_q[$];
        int          n_checked, n_errors;
        int          n_sleep, n_power_off, n_locked;

        function new();
            lp_ticks     = LOW_POWER_TICKS_RST;
            lock_ticks   = LOCK_TICKS_RST;
            sleep_ticks  = SLEEP_TICKS_RST;
            idle_ticks   = IDLE_OFF_TICKS_RST;
            presence_cnt = 0;
            full_cnt     = FULL_RESET;
            lp_cnt       = 0;
            sleep_cnt    = 0;
            idle_cnt     = 0;
            connected    = 0;
            full         = 0;
            locked       = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data val);
            case (idx)
                CFG_LOW_POWER_TICKS: lp_ticks    = val;
                CFG_LOCK_TICKS:      lock_ticks  = val;
                CFG_SLEEP_TICKS:     sleep_ticks = val;
                CFG_IDLE_OFF_TICKS:  idle_ticks  = val;
                default: ;
            endcase
        endfunction

        // Advance the supervisor by one tick and queue the status it gives
        function void take_tick(t_in_item it);
            int      lvl;
            int      disp;
            bit      slp, off, stop;
            t_result r;
            lvl  = int'($signed(it.battery_level));
            slp  = 0;
            off  = 0;
            stop = 0;

            // debounce charger presence
            if (it.vin_present) begin
                if (presence_cnt < PRESENCE_MAX) presence_cnt++;
                else connected = 1;
            end else if (it.switch_off) begin
                full_cnt     = FULL_RESET;
                presence_cnt = 0;
                connected    = 0;
            end else begin
                full_cnt = FULL_RESET;
                if (presence_cnt != 0) presence_cnt--;
                else connected = 0;
            end

            // debounce charge-full: down by one, up by a step
            if (it.charge_pin) begin
                if (full_cnt != 0) full_cnt--;
                else full = 0;
            end else begin
                if (full_cnt < FULL_MAX) full_cnt += FULL_STEP;
                else full = 1;
            end

            // track low power and pick the displayed level
            if (connected) begin
                if (full) begin
                    if (lp_cnt > LP_DRAIN) begin
                        lp_cnt -= LP_DRAIN;
                    end else begin
                        lp_cnt = 0;
                        locked = 0;
                    end
                    disp = LEVEL_CAP;
                end else begin
                    if (lp_cnt != 0) begin
                        lp_cnt--;
                        if (lvl > LEVEL_LOW) locked = 0;
                    end
                    disp = (lvl > LEVEL_CAP) ? LEVEL_CAP : lvl;
                end
            end else if (lvl == LEVEL_EMPTY || locked) begin
                disp = LEVEL_EMPTY;
                if (lp_cnt < lock_ticks) lp_cnt = (lp_cnt + 1) & CNT_MASK;
                else locked = 1;
            end else if (lvl == LEVEL_CRITICAL) begin
                disp = LEVEL_EMPTY;
                if (lp_cnt < lp_ticks) begin
                    lp_cnt = (lp_cnt + 1) & CNT_MASK;
                    // prime the sleep counter
                    if (lp_cnt >= lp_ticks) sleep_cnt = (sleep_ticks - 1) & CNT_MASK;
                end
            end else begin
                disp = lvl;
                if (lvl > LEVEL_LOW && lp_cnt != 0) begin
                    lp_cnt--;
                    locked = 0;
                end
            end

            // run the sleep and idle-off timers
            if (it.power_mode == MODE_OFF_FULL || it.power_mode == MODE_OFF_CHARGING) begin
                sleep_cnt = 0;
            end else if (it.power_mode == MODE_OFF_NO_CHARGE ||
                         it.power_mode == MODE_OFF_NO_CHARGE_FUL) begin
                if (sleep_cnt < sleep_ticks) begin
                    sleep_cnt = (sleep_cnt + 1) & CNT_MASK;
                end else if (!it.key_level) begin
                    sleep_cnt = 0;
                    lp_cnt    = 0;
                    if (!connected) begin
                        slp      = 1;
                        stop     = 1;
                        idle_cnt = 0;
                    end
                end
            end else if (it.power_mode <= MODE_ON_CHARGING) begin
                sleep_cnt = 0;
                if (lp_cnt < lp_ticks) begin
                    if (connected) begin
                        idle_cnt = 0;
                    end else if (idle_ticks > idle_cnt) begin
                        idle_cnt = (idle_cnt + 1) & CNT_MASK;
                    end else begin
                        off  = 1;
                        stop = 1;
                    end
                end
            end else begin
                lp_cnt    = 0;
                sleep_cnt = 0;
            end

            r.charger_connected = connected;
            r.battery_full      = full;
            r.display_level     = 4'(disp);
            r.low_power_locked  = locked;
            r.charge_stable     = (full_cnt >= FULL_MAX || full_cnt == 0) &&
                                  (presence_cnt >= PRESENCE_MAX || presence_cnt == 0);
            r.sleep_entry       = slp;
            r.power_off_request = off;
            r.display_stop      = stop;
            status_q.push_back(r);
            n_sleep     += slp;
            n_power_off += off;
            n_locked    += locked;
        endfunction

        function string show(t_result r);
            return $sformatf({"conn=%0b full=%0b lvl=%0d lock=%0b stable=%0b",
                              " sleep=%0b off=%0b stop=%0b"},
                             r.charger_connected, r.battery_full, $signed(r.display_level),
                             r.low_power_locked, r.charge_stable, r.sleep_entry,
                             r.power_off_request, r.display_stop);
        endfunction

        // Compare one status transfer with the oldest queued status
        function void check_status(t_result got);
            t_result want;
            bit      bad;
            if (status_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) $display("Unexpected status: %s", show(got));
                return;
            end
            want = status_q.pop_front();
            n_checked++;
            bad = (got.charger_connected !== want.charger_connected) ||
                  (got.battery_full      !== want.battery_full)      ||
                  (got.display_level     !== want.display_level)     ||
                  (got.low_power_locked  !== want.low_power_locked)  ||
                  (got.charge_stable     !== want.charge_stable)     ||
                  (got.sleep_entry       !== want.sleep_entry)       ||
                  (got.power_off_request !== want.power_off_request) ||
                  (got.display_stop      !== want.display_stop);
            if (bad) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("Status mismatch at tick %0d:\n  expected %s\n  actual   %s",
                             n_checked, show(want), show(got));
            end
        endfunction

        function void check_leftover();
            if (status_q.size() != 0) begin
                n_errors++;
                $display("%0d expected status items never arrived", status_q.size());
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    chs_cfg_if cfg_ch ();
    chs_in_if  in_ch ();
    chs_out_if out_ch ();

    charger_and_sleep_supervisor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    supervisor_scoreboard sb;
    int n_sent;
    int n_phases;
    int stuck_cycles;
    bit calm;
    bit hold_req;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Status sink: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Observe every transfer and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
                sb.write_reg(cfg_ch.data.index, cfg_ch.data.value);
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                sb.take_tick(in_ch.data);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_status(out_ch.data);
            if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
                (out_ch.valid && out_ch.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", stuck_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic t_in_item mk_item(bit vin, bit chg, bit key, logic signed [3:0] lvl,
                                         t_mode mode, bit sw);
        t_in_item it;
        it.vin_present   = vin;
        it.charge_pin    = chg;
        it.key_level     = key;
        it.battery_level = lvl;
        it.power_mode    = mode;
        it.switch_off    = sw;
        return it;
    endfunction

    function automatic t_cfg_data pick_reg();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return t_cfg_data'($urandom_range(1, 40));
        endcase
    endfunction

    // Offer one tick item, idling at random first
    task automatic send_item(input t_in_item it);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        n_sent++;
    endtask

    // Drop valid and hold until every queued status has come back
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        while (sb.n_checked < n_sent) @(posedge i_clk);
    endtask

    task automatic write_regs(input t_cfg_data lp, lk, sl, io, input bit spare);
        t_cfg_write wq[$];
        wq.push_back('{index: CFG_LOW_POWER_TICKS, value: lp});
        wq.push_back('{index: CFG_LOCK_TICKS,      value: lk});
        wq.push_back('{index: CFG_SLEEP_TICKS,     value: sl});
        wq.push_back('{index: CFG_IDLE_OFF_TICKS,  value: io});
        if (spare) wq.push_back('{index: CFG_IDX_SPARE, value: 16'hA5A5});
        foreach (wq[k]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= wq[k];
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // A run of ticks with steady pins and mode, with occasional glitches
    task automatic run_episode();
        int    len;
        int    lvl;
        bit    vin, chg, sw;
        t_mode mode;
        t_in_item it;
        len  = $urandom_range(4, 48);
        vin  = 1'($urandom_range(0, 1));
        chg  = 1'($urandom_range(0, 1));
        sw   = ($urandom_range(0, 3) == 0);
        mode = ($urandom_range(0, 9) < 9) ? t_mode'($urandom_range(0, 7))
                                          : t_mode'($urandom_range(8, 15));
        case ($urandom_range(0, 5))
            0:       lvl = LEVEL_CRITICAL;
            1:       lvl = LEVEL_EMPTY;
            2:       lvl = LEVEL_LOW;
            3:       lvl = $urandom_range(2, 7);
            4:       lvl = LEVEL_UNMEASURED;
            default: lvl = $signed(4'($urandom));
        endcase
        repeat (len) begin
            it = mk_item(($urandom_range(0, 19) == 0) ? !vin : vin,
                         ($urandom_range(0, 19) == 0) ? !chg : chg,
                         $urandom_range(0, 4) != 0,
                         ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'(lvl),
                         mode, sw);
            send_item(it);
        end
    endtask

    // Settle, load the registers, then drive random ticks
    task automatic run_phase(input t_cfg_data lp, lk, sl, io, input bit spare, input bit hold);
        int target;
        wait_results();
        write_regs(lp, lk, sl, io, spare);
        n_phases++;
        if (hold) hold_req = 1'b1;
        target = n_sent + PHASE_ITEMS;
        while (n_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
                run_episode();
            end else begin
                repeat ($urandom_range(1, 5)) send_item(t_in_item'($urandom));
            end
        end
    endtask

    // Main sequence
    initial begin
        sb           = new();
        n_sent       = 0;
        n_phases     = 1;
        stuck_cycles = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at reset register values: connect, go full, then each path
        repeat (7) send_item(mk_item(1, 0, 1, 4'sd7, MODE_ON_CHARGING, 0));
        send_item(mk_item(1, 0, 1, -4'sd8, MODE_ON_FULL, 0));
        send_item(mk_item(1, 1, 0, 4'sd5, MODE_ON_NO_CHARGE_FULL, 1));
        send_item(mk_item(0, 1, 0, LEVEL_CRITICAL, MODE_OFF_NO_CHARGE, 1));
        send_item(mk_item(0, 0, 0, LEVEL_EMPTY, MODE_OFF_NO_CHARGE_FUL, 0));
        send_item(mk_item(0, 0, 1, LEVEL_UNMEASURED, MODE_ON_NO_CHARGE, 0));
        send_item(mk_item(0, 1, 1, LEVEL_CRITICAL, MODE_OFF_FULL, 0));
        send_item(mk_item(0, 0, 1, LEVEL_LOW, MODE_OFF_CHARGING, 1));
        for (int k = MODE_OTHER; k <= MODE_TOP; k++)
            send_item(mk_item(k[0], k[1], k[2], 4'(k * 5), t_mode'(k), k[3]));

        // register settings: minimum, zero, sleep wrap, maximum, a calm run, then random
        run_phase(16'd1, 16'd1, 16'd1, 16'd1, 1'b1, 1'b0);
        run_phase('0, '0, '0, '0, 1'b0, 1'b0);
        run_phase(16'd3, 16'd2, '0, 16'd5, 1'b0, 1'b1);
        run_phase('1, '1, '1, '1, 1'b0, 1'b0);
        calm = 1'b1;
        run_phase(16'd6, 16'd4, 16'd8, 16'd12, 1'b0, 1'b0);
        calm = 1'b0;
        repeat (5) run_phase(pick_reg(), pick_reg(), pick_reg(), pick_reg(), 1'b0, 1'b0);

        // drain and let any stray status show up
        wait_results();
        repeat (4) @(posedge i_clk);
        sb.check_leftover();

        $display("Ran %0d ticks under %0d register settings, %0d status items checked",
                 n_sent, n_phases, sb.n_checked);
        $display("Saw %0d sleep entries, %0d power-off requests, %0d locked ticks",
                 sb.n_sleep, sb.n_power_off, sb.n_locked);
        if (sb.n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures", sb.n_errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/chs_pkg.sv
hw/rtl/chs_intf.sv
hw/rtl/charger_and_sleep_supervisor.sv
tb/tb_charger_and_sleep_supervisor.sv
